// ----- sv/sine_tone_generator_assert.svh -----
// assertion macros for the sine tone generator
`ifndef SINE_TONE_GENERATOR_ASSERT_SVH
`define SINE_TONE_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define STG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// condition that must never be seen outside reset
`define STG_NEVER(lbl, clk, rst_n, cond, msg) \
  `STG_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define STG_ASSERT(lbl, clk, rst_n, prop, msg)
`define STG_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- sv/stg_pkg.sv -----
// types, constants and codes shared by the sine tone generator files
package stg_pkg;

  localparam int unsigned RATE_W   = 17;
  localparam int unsigned FREQ_W   = 15;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned FRAMES_W = 23;

  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF     = 16;

  // serial unit operand width and fixed point format of the sine polynomial
  localparam int unsigned OP_W      = 32;
  localparam int unsigned Q_FRAC    = 30;
  localparam int unsigned HD_W      = 32;
  localparam int unsigned FR_PROD_W = RATE_W + DUR_W;

  localparam logic [RATE_W-1:0]   RATE_RESET  = RATE_W'(44100);
  localparam logic [OP_W-1:0]     MS_PER_S    = OP_W'(1000);
  localparam logic [OP_W-1:0]     Q30_ONE     = OP_W'(1073741824);
  localparam logic [OP_W-1:0]     HALF_PI_Q30 = OP_W'(1686629713);
  localparam logic [FRAMES_W-1:0] FRAMES_MAX  = '1;

  // taylor divisors, innermost term first
  localparam int unsigned HORNER_N = 5;
  localparam int unsigned HK_W     = $clog2(HORNER_N);
  localparam logic [OP_W-1:0] HORNER_DIV [HORNER_N] = '{
    OP_W'(110), OP_W'(72), OP_W'(42), OP_W'(20), OP_W'(6)
  };

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } stg_func_e;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } stg_alu_op_e;

  typedef struct packed {
    logic        start;
    stg_alu_op_e op;
  } stg_alu_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMUL,
    S_FDIV,
    S_PDIV,
    S_TX,
    S_TX2,
    S_THM,
    S_THD,
    S_TXT,
    S_TAS,
    S_TFS,
    S_EMIT
  } stg_state_e;

endpackage

// ----- sv/stg_if.sv -----
// valid/ready channels for tone commands and pcm results
interface stg_in_if;
  import stg_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [FREQ_W-1:0] freq_hz;
  logic [DUR_W-1:0]  duration_ms;
  logic [AMP_W-1:0]  amplitude_q15;

  modport source (output valid, func, freq_hz, duration_ms, amplitude_q15, input ready);
  modport sink   (input valid, func, freq_hz, duration_ms, amplitude_q15, output ready);
endinterface

interface stg_out_if #(
  parameter int unsigned SAMPLE_BITS = stg_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          active;
  logic                          last;

  modport source (output valid, sample, active, last, input ready);
  modport sink   (input valid, sample, active, last, output ready);
endinterface

// ----- sv/stg_serial_alu.sv -----
// bit-serial shift-add multiplier and restoring divider, one bit per cycle
module stg_serial_alu #(
  parameter int unsigned ACC_W = 64,
  parameter int unsigned OP_W  = stg_pkg::OP_W,
  parameter int unsigned CNT_W = $clog2(ACC_W + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stg_pkg::stg_alu_ctl_t ctl_i,
  input  logic [CNT_W-1:0]      cnt_i,
  input  logic [OP_W-1:0]       a_i,
  input  logic [ACC_W-1:0]      b_i,
  output logic [ACC_W-1:0]      res_o,
  output logic                  done_o
);
  import stg_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  stg_alu_op_e       op_q;
  logic [OP_W-1:0]   opd_q;
  logic [OP_W-1:0]   mplr_q;
  logic [OP_W-1:0]   rem_q;
  logic [ACC_W-1:0]  prod_q;

  logic [OP_W:0]     trial;
  logic              ge;
  logic [ACC_W-1:0]  mul_sum;

  // divide: next dividend bit joins the partial remainder
  assign trial = {rem_q, prod_q[ACC_W-1]};
  assign ge    = trial >= {1'b0, opd_q};
  // multiply: msb-first over the multiplier
  assign mul_sum = {prod_q[ACC_W-2:0], 1'b0} + (mplr_q[OP_W-1] ? ACC_W'(opd_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_MUL;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= cnt_i;
      op_q   <= ctl_i.op;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      opd_q  <= a_i;
      mplr_q <= b_i[OP_W-1:0];
      rem_q  <= '0;
      prod_q <= (ctl_i.op == ALU_DIV) ? b_i : '0;
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        prod_q <= mul_sum;
        mplr_q <= {mplr_q[OP_W-2:0], 1'b0};
      end else begin
        rem_q  <= ge ? OP_W'(trial - {1'b0, opd_q}) : trial[OP_W-1:0];
        prod_q <= {prod_q[ACC_W-2:0], ge};
      end
    end
  end

  assign res_o  = prod_q;
  assign done_o = done_q;

endmodule

// ----- sv/sine_tone_generator.sv -----
// sine tone generator: phase accumulator and a serially evaluated taylor sine
// start item: a multiply for the frame count, then a divide by 1000, then the phase step divide
// tick in a tone: 15 serial 32-bit ops through one unit
// idle tick: goes straight to the emit state with no serial ops; one item at a time, ready only when idle
// the output register holds a result while the next item is taken
// reset clears phase, step, frame count and level, and sets the output rate to 44100
module sine_tone_generator #(
  parameter int unsigned PHASE_BITS      = stg_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = stg_pkg::SINE_TABLE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS     = stg_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [stg_pkg::RATE_W-1:0] cfg_wdata_i,
  stg_in_if.sink                     item_i,
  stg_out_if.source                  result_o
);
  `include "sine_tone_generator_assert.svh"
  import stg_pkg::*;

  localparam int unsigned ACC_W = (2 * OP_W > FREQ_W + PHASE_BITS) ?
                                  2 * OP_W : FREQ_W + PHASE_BITS;
  localparam int unsigned CNT_W = $clog2(ACC_W + 1);
  localparam int unsigned M_W   = SINE_TABLE_BITS - 1;
  localparam logic [M_W-1:0]  QLEN = M_W'(2 ** (SINE_TABLE_BITS - 2));
  localparam logic [OP_W-1:0] FULL_SCALE = OP_W'((2 ** (SAMPLE_BITS - 1)) - 1);

  stg_state_e state_q, state_d;

  logic [RATE_W-1:0]      rate_q, rate_d;
  logic [PHASE_BITS-1:0]  phase_q, phase_d;
  logic [PHASE_BITS-1:0]  step_q, step_d;
  logic [FRAMES_W-1:0]    frames_q, frames_d;
  logic [AMP_W-1:0]       peak_q, peak_d;
  logic                   out_valid_q, out_valid_d;

  logic [FREQ_W-1:0]      freq_q, freq_d;
  logic [OP_W-1:0]        x_q, x_d;
  logic [OP_W-1:0]        x2_q, x2_d;
  logic [HK_W-1:0]        k_q, k_d;
  logic [SAMPLE_BITS-1:0] smp_q, smp_d;
  logic                   act_q, act_d;
  logic [SAMPLE_BITS-1:0] out_sample_q, out_sample_d;
  logic                   out_active_q, out_active_d;
  logic                   out_last_q, out_last_d;

  stg_alu_ctl_t           alu_ctl;
  logic [CNT_W-1:0]       alu_cnt;
  logic [OP_W-1:0]        alu_a;
  logic [ACC_W-1:0]       alu_b;
  logic [ACC_W-1:0]       alu_res;
  logic                   alu_done;

  logic                     in_fire;
  logic                     emit_fire;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]               quad;
  logic [M_W-1:0]           r_ext;
  logic [M_W-1:0]           m_val;
  logic [OP_W-1:0]          x_new;
  logic [OP_W-1:0]          x2_new;
  logic [OP_W-1:0]          t_new;
  logic [ACC_W-1:0]         s_raw;
  logic [OP_W-1:0]          s_val;
  logic [OP_W-1:0]          v_new;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [FRAMES_W-1:0]      frames_sat;
  logic [ACC_W-1:0]         hd_dvd;

  stg_serial_alu #(
    .ACC_W (ACC_W),
    .OP_W  (OP_W),
    .CNT_W (CNT_W)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .cnt_i  (alu_cnt),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .done_o (alu_done)
  );

  assign in_fire   = item_i.valid && item_i.ready;
  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || result_o.ready);

  // quarter-wave fold of the phase
  assign idx   = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad  = idx[SINE_TABLE_BITS-1 -: 2];
  assign r_ext = {1'b0, idx[SINE_TABLE_BITS-3:0]};
  assign m_val = quad[0] ? QLEN - r_ext : r_ext;

  assign x_new  = OP_W'(alu_res >> (SINE_TABLE_BITS - 2));
  assign x2_new = OP_W'(alu_res >> Q_FRAC);
  assign t_new  = (alu_res >= ACC_W'(Q30_ONE)) ? '0 : Q30_ONE - alu_res[OP_W-1:0];
  assign s_raw  = alu_res >> Q_FRAC;
  assign s_val  = (s_raw > ACC_W'(Q30_ONE)) ? Q30_ONE : s_raw[OP_W-1:0];
  assign v_new  = OP_W'(alu_res >> AMP_W);
  assign mag    = alu_res[Q_FRAC +: SAMPLE_BITS];
  assign hd_dvd = (alu_res >> Q_FRAC) << (ACC_W - HD_W);
  assign frames_sat = (|alu_res[ACC_W-1:FRAMES_W]) ? FRAMES_MAX : alu_res[FRAMES_W-1:0];

  always_comb begin
    state_d      = state_q;
    rate_d       = rate_q;
    phase_d      = phase_q;
    step_d       = step_q;
    frames_d     = frames_q;
    peak_d       = peak_q;
    freq_d       = freq_q;
    x_d          = x_q;
    x2_d         = x2_q;
    k_d          = k_q;
    smp_d        = smp_q;
    act_d        = act_q;
    out_sample_d = out_sample_q;
    out_active_d = out_active_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q;
    alu_ctl      = '{start: 1'b0, op: ALU_MUL};
    alu_cnt      = '0;
    alu_a        = '0;
    alu_b        = '0;

    if (cfg_we_i) begin
      rate_d = cfg_wdata_i;
    end
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (item_i.func == FUNC_TICK) begin
            if (frames_q == '0) begin
              smp_d   = '0;
              act_d   = 1'b0;
              state_d = S_EMIT;
            end else begin
              alu_ctl = '{start: 1'b1, op: ALU_MUL};
              alu_cnt = CNT_W'(OP_W);
              alu_a   = HALF_PI_Q30;
              alu_b   = ACC_W'(m_val);
              state_d = S_TX;
            end
          end else if (item_i.freq_hz != '0) begin
            // frame count first: rate * duration
            freq_d  = item_i.freq_hz;
            peak_d  = item_i.amplitude_q15;
            alu_ctl = '{start: 1'b1, op: ALU_MUL};
            alu_cnt = CNT_W'(OP_W);
            alu_a   = OP_W'(rate_q);
            alu_b   = ACC_W'(item_i.duration_ms);
            state_d = S_FMUL;
          end
        end
      end
      S_FMUL: begin
        if (alu_done) begin
          alu_ctl = '{start: 1'b1, op: ALU_DIV};
          alu_cnt = CNT_W'(FR_PROD_W);
          alu_a   = MS_PER_S;
          alu_b   = alu_res << (ACC_W - FR_PROD_W);
          state_d = S_FDIV;
        end
      end
      S_FDIV: begin
        if (alu_done) begin
          // phase step: (freq << PHASE_BITS) / rate, zero rate gives all ones
          frames_d = frames_sat;
          alu_ctl  = '{start: 1'b1, op: ALU_DIV};
          alu_cnt  = CNT_W'(FREQ_W + PHASE_BITS);
          alu_a    = OP_W'(rate_q);
          alu_b    = ACC_W'(freq_q) << (ACC_W - FREQ_W);
          state_d  = S_PDIV;
        end
      end
      S_PDIV: begin
        if (alu_done) begin
          step_d  = alu_res[PHASE_BITS-1:0];
          phase_d = '0;
          state_d = S_IDLE;
        end
      end
      S_TX: begin
        if (alu_done) begin
          x_d     = x_new;
          alu_ctl = '{start: 1'b1, op: ALU_MUL};
          alu_cnt = CNT_W'(OP_W);
          alu_a   = x_new;
          alu_b   = ACC_W'(x_new);
          state_d = S_TX2;
        end
      end
      S_TX2: begin
        if (alu_done) begin
          x2_d    = x2_new;
          k_d     = '0;
          alu_ctl = '{start: 1'b1, op: ALU_MUL};
          alu_cnt = CNT_W'(OP_W);
          alu_a   = x2_new;
          alu_b   = ACC_W'(Q30_ONE);
          state_d = S_THM;
        end
      end
      S_THM: begin
        if (alu_done) begin
          alu_ctl = '{start: 1'b1, op: ALU_DIV};
          alu_cnt = CNT_W'(HD_W);
          alu_a   = HORNER_DIV[k_q];
          alu_b   = hd_dvd;
          state_d = S_THD;
        end
      end
      S_THD: begin
        if (alu_done) begin
          alu_ctl = '{start: 1'b1, op: ALU_MUL};
          alu_cnt = CNT_W'(OP_W);
          alu_b   = ACC_W'(t_new);
          if (k_q == HK_W'(HORNER_N - 1)) begin
            alu_a   = x_q;
            state_d = S_TXT;
          end else begin
            k_d     = k_q + 1'b1;
            alu_a   = x2_q;
            state_d = S_THM;
          end
        end
      end
      S_TXT: begin
        if (alu_done) begin
          alu_ctl = '{start: 1'b1, op: ALU_MUL};
          alu_cnt = CNT_W'(OP_W);
          alu_a   = s_val;
          alu_b   = ACC_W'(peak_q);
          state_d = S_TAS;
        end
      end
      S_TAS: begin
        if (alu_done) begin
          alu_ctl = '{start: 1'b1, op: ALU_MUL};
          alu_cnt = CNT_W'(OP_W);
          alu_a   = v_new;
          alu_b   = ACC_W'(FULL_SCALE);
          state_d = S_TFS;
        end
      end
      S_TFS: begin
        if (alu_done) begin
          // lower half of the wave is negative
          smp_d   = quad[1] ? '0 - mag : mag;
          act_d   = 1'b1;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          out_valid_d  = 1'b1;
          out_sample_d = smp_q;
          out_active_d = act_q;
          out_last_d   = act_q && (frames_q == FRAMES_W'(1));
          if (act_q) begin
            phase_d  = phase_q + step_q;
            frames_d = frames_q - 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= RATE_RESET;
      phase_q     <= '0;
      step_q      <= '0;
      frames_q    <= '0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rate_q      <= rate_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      frames_q    <= frames_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q       <= freq_d;
    x_q          <= x_d;
    x2_q         <= x2_d;
    k_q          <= k_d;
    smp_q        <= smp_d;
    act_q        <= act_d;
    out_sample_q <= out_sample_d;
    out_active_q <= out_active_d;
    out_last_q   <= out_last_d;
  end

  assign item_i.ready    = (state_q == S_IDLE);
  assign result_o.valid  = out_valid_q;
  assign result_o.sample = out_sample_q;
  assign result_o.active = out_active_q;
  assign result_o.last   = out_last_q;

  `STG_ASSERT(a_done_in_compute, clk_i, rst_ni, alu_done |-> (state_q != S_IDLE && state_q != S_EMIT), "serial unit finished outside a compute state")
  `STG_ASSERT(a_last_active, clk_i, rst_ni, out_valid_q && out_last_q |-> out_active_q, "last beat flagged on an idle result")
  `STG_ASSERT(a_idle_zero, clk_i, rst_ni, out_valid_q && !out_active_q |-> out_sample_q == '0, "idle result carries a nonzero sample")
  `STG_ASSERT(a_frame_count, clk_i, rst_ni, emit_fire && act_q |=> frames_q == $past(frames_q) - 1'b1, "frame count not stepped on an active beat")

endmodule

// ----- tb/tb_sine_tone_generator.sv -----
// self-checking testbench for the sine tone generator: tone commands in, pcm beats checked out
module tb_sine_tone_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import stg_pkg::*;

  localparam int unsigned RESET_CYCLES  = 11;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned CFG_SETTLE    = 200;
  localparam int unsigned END_SETTLE    = 600;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned ERR_PRINT_MAX = 100;

  localparam int unsigned PH_W  = PHASE_BITS_DEF;
  localparam int unsigned TBL_W = SINE_TABLE_BITS_DEF;
  localparam int unsigned SMP_W = SAMPLE_BITS_DEF;

  localparam logic [63:0] ONE_Q30          = 64'd1073741824;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [63:0] MS_DIV           = 64'd1000;
  localparam logic [63:0] FRAME_CAP        = (64'd1 << FRAMES_W) - 64'd1;
  localparam logic [63:0] FULL_SCALE       = (64'd1 << (SMP_W - 1)) - 64'd1;
  localparam logic [RATE_W-1:0] RATE_AFTER_RESET = RATE_W'(44100);
  localparam logic [RATE_W-1:0] RATE_MIN         = RATE_W'(8000);
  localparam logic [RATE_W-1:0] RATE_MAX_USE     = RATE_W'(96000);
  localparam logic [FREQ_W-1:0] FREQ_MAX_USE     = FREQ_W'(24000);

  typedef struct {
    logic signed [SMP_W-1:0] sample;
    logic                    active;
    logic                    last;
  } pcm_beat_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [RATE_W-1:0] cfg_wdata;

  stg_in_if                        item_if ();
  stg_out_if #(.SAMPLE_BITS(SMP_W)) pcm_if ();

  sine_tone_generator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (pcm_if)
  );

  // tone generator state as the testbench sees it
  logic [RATE_W-1:0]   tone_rate;
  logic [PH_W-1:0]     tone_phase;
  logic [PH_W-1:0]     tone_step;
  logic [FRAMES_W-1:0] tone_frames_left;
  logic [AMP_W-1:0]    tone_level;

  pcm_beat_t pending_pcm_q [$];

  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned accepted_cnt;
  int unsigned sink_hold_left;
  int unsigned stall_left;
  bit          src_idle_en;
  bit          sink_idle_en;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
               pending_pcm_q.size());
      $display("sine_tone_generator verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < ERR_PRINT_MAX) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    mismatch_cnt++;
  endtask

  function automatic logic [63:0] taylor_div(input int k);
    case (k)
      0:       return 64'd110;
      1:       return 64'd72;
      2:       return 64'd42;
      3:       return 64'd20;
      default: return 64'd6;
    endcase
  endfunction

  // quarter wave magnitude in q30 for an angle in q2.30
  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    int          k;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (k = 0; k < 5; k++) begin
      d = ((x2 * t) >> 30) / taylor_div(k);
      t = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    end
    t = (x * t) >> 30;
    return (t > ONE_Q30) ? ONE_Q30 : t;
  endfunction

  function automatic logic signed [SMP_W-1:0] pcm_from_phase();
    logic [63:0] idx;
    logic [63:0] quad;
    logic [63:0] qlen;
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] mag;
    logic [63:0] v;
    idx  = (64'(tone_phase) >> (PH_W - TBL_W)) & ((64'd1 << TBL_W) - 64'd1);
    quad = idx >> (TBL_W - 2);
    qlen = 64'd1 << (TBL_W - 2);
    r    = idx & (qlen - 64'd1);
    // odd quadrants run the quarter wave backwards
    m    = quad[0] ? qlen - r : r;
    x    = (m * QUARTER_TURN_Q30) >> (TBL_W - 2);
    mag  = (((64'(tone_level) * quarter_sine_q30(x)) >> 15) * FULL_SCALE) >> 30;
    v    = quad[1] ? (64'd0 - mag) : mag;
    return v[SMP_W-1:0];
  endfunction

  task automatic tone_model_step(input stg_func_e fn, input logic [FREQ_W-1:0] freq,
                                 input logic [DUR_W-1:0] dur, input logic [AMP_W-1:0] amp);
    logic [63:0] frames;
    pcm_beat_t   beat;
    if (fn == FUNC_START) begin
      if (freq != '0) begin
        if (tone_rate == '0) tone_step = '1;
        else tone_step = PH_W'((64'(freq) << PH_W) / 64'(tone_rate));
        frames           = (64'(tone_rate) * 64'(dur)) / MS_DIV;
        tone_frames_left = (frames > FRAME_CAP) ? FRAMES_W'(FRAME_CAP) : FRAMES_W'(frames);
        tone_phase       = '0;
        tone_level       = amp;
      end
    end else if (tone_frames_left == '0) begin
      beat.sample = '0;
      beat.active = 1'b0;
      beat.last   = 1'b0;
      pending_pcm_q.push_back(beat);
    end else begin
      beat.sample      = pcm_from_phase();
      beat.active      = 1'b1;
      tone_phase       = tone_phase + tone_step;
      tone_frames_left = tone_frames_left - 1'b1;
      beat.last        = (tone_frames_left == '0);
      pending_pcm_q.push_back(beat);
    end
  endtask

  task automatic send_item(input stg_func_e fn, input logic [FREQ_W-1:0] freq,
                           input logic [DUR_W-1:0] dur, input logic [AMP_W-1:0] amp);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_if.valid         <= 1'b1;
    item_if.func          <= fn;
    item_if.freq_hz       <= freq;
    item_if.duration_ms   <= dur;
    item_if.amplitude_q15 <= amp;
    do @(posedge clk); while (!item_if.ready);
    tone_model_step(fn, freq, dur, amp);
    if (!(fn == FUNC_START && freq == '0)) accepted_cnt++;
  endtask

  // tick fields carry no meaning, so fill them with noise
  task automatic send_tick();
    send_item(FUNC_TICK, FREQ_W'($urandom), DUR_W'($urandom), AMP_W'($urandom));
  endtask

  task automatic wait_results_done();
    item_if.valid <= 1'b0;
    while (pending_pcm_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_rate_reg(input logic [RATE_W-1:0] rate);
    wait_results_done();
    // a start beat leaves no result, let the divider finish first
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tone_rate = rate;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pcm_if.ready <= 1'b0;
    end else if (sink_hold_left > 0) begin
      pcm_if.ready <= 1'b0;
      sink_hold_left--;
    end else if (stall_left > 0) begin
      pcm_if.ready <= 1'b0;
      stall_left--;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      pcm_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      pcm_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : pcm_check
    pcm_beat_t want;
    if (rst_n && pcm_if.valid && pcm_if.ready) begin
      if (pending_pcm_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat sample %0d active %b last %b",
                                  pcm_if.sample, pcm_if.active, pcm_if.last));
      end else begin
        want = pending_pcm_q.pop_front();
        if (pcm_if.sample !== want.sample)
          report_mismatch($sformatf("sample got %0d want %0d", pcm_if.sample, want.sample));
        if (pcm_if.active !== want.active)
          report_mismatch($sformatf("active got %b want %b", pcm_if.active, want.active));
        if (pcm_if.last !== want.last)
          report_mismatch($sformatf("last got %b want %b", pcm_if.last, want.last));
      end
    end
  end

  task automatic test_idle_ticks();
    send_tick();
    send_item(FUNC_START, '0, '1, '1);
    send_tick();
  endtask

  task automatic test_short_tones();
    write_rate_reg(RATE_MIN);
    // top frequency at the lowest rate wraps the step
    send_item(FUNC_START, FREQ_MAX_USE, DUR_W'(1), '1);
    repeat (2) send_tick();
    send_item(FUNC_START, '0, '1, '1);
    send_tick();
    // replaces the running tone with one of no frames
    send_item(FUNC_START, FREQ_W'(500), '0, '0);
    send_tick();
    send_item(FUNC_START, FREQ_W'(1000), DUR_W'(1), '1);
    repeat (9) send_tick();
  endtask

  task automatic test_zero_rate();
    write_rate_reg('0);
    send_item(FUNC_START, FREQ_W'(1), '1, '1);
    send_tick();
  endtask

  task automatic test_frame_saturation();
    write_rate_reg('1);
    send_item(FUNC_START, '1, '1, '1);
    repeat (2) send_tick();
  endtask

  task automatic test_backpressure();
    bit saved_idle;
    write_rate_reg(RATE_MIN);
    send_item(FUNC_START, FREQ_W'(1000), DUR_W'(2), AMP_W'(20000));
    saved_idle     = src_idle_en;
    src_idle_en    = 1'b0;
    sink_hold_left = HOLD_CYCLES;
    repeat (12) send_tick();
    src_idle_en = saved_idle;
    wait_results_done();
  endtask

  task automatic test_random_tones(input logic [RATE_W-1:0] rate, input int unsigned n_items);
    int unsigned       target;
    int unsigned       n_ticks;
    int unsigned       pick;
    logic [FREQ_W-1:0] f;
    logic [DUR_W-1:0]  d;
    logic [AMP_W-1:0]  a;
    write_rate_reg(rate);
    target = accepted_cnt + n_items;
    while (accepted_cnt < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_tick();
      end else if (pick == 1) begin
        send_item(FUNC_START, FREQ_W'($urandom), DUR_W'($urandom), AMP_W'($urandom));
      end else begin
        f = ($urandom_range(0, 7) == 0) ? FREQ_W'($urandom_range(1, (1 << FREQ_W) - 1))
                                        : FREQ_W'($urandom_range(1, FREQ_MAX_USE));
        pick = $urandom_range(0, 9);
        // short tones mostly, so the last frame comes around often
        if (pick < 7) d = DUR_W'($urandom_range(0, 3));
        else if (pick < 9) d = DUR_W'($urandom_range(4, 40));
        else d = DUR_W'($urandom);
        if ($urandom_range(0, 9) == 0) a = $urandom_range(0, 1) ? '1 : '0;
        else a = AMP_W'($urandom);
        send_item(FUNC_START, f, d, a);
        if (tone_frames_left <= 48 && $urandom_range(0, 1) == 1)
          n_ticks = int'(tone_frames_left) + $urandom_range(0, 2);
        else
          n_ticks = $urandom_range(1, 8);
        repeat (n_ticks) send_tick();
      end
    end
  endtask

  initial begin : main_seq
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    item_if.valid         <= 1'b0;
    item_if.func          <= FUNC_START;
    item_if.freq_hz       <= '0;
    item_if.duration_ms   <= '0;
    item_if.amplitude_q15 <= '0;
    tone_rate        = RATE_AFTER_RESET;
    tone_phase       = '0;
    tone_step        = '0;
    tone_frames_left = '0;
    tone_level       = '0;
    src_idle_en      = 1'b1;
    sink_idle_en     = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_short_tones();
    test_zero_rate();
    test_frame_saturation();
    test_backpressure();
    test_random_tones(RATE_MIN, 200);
    test_random_tones(RATE_MAX_USE, 150);
    test_random_tones(RATE_W'($urandom_range(RATE_MIN, RATE_MAX_USE)), 150);
    test_random_tones(RATE_W'($urandom), 150);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_tones(RATE_AFTER_RESET, 150);

    wait_results_done();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_pcm_q.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", pending_pcm_q.size()));
    if (mismatch_cnt == 0) begin
      $display("sine_tone_generator verification clean");
    end else begin
      $display("sine_tone_generator verification failed");
    end
    $finish;
  end

endmodule
